/* sv/irhst_pkg.sv */
// Package for the ICMP reply host status table.
// Holds the beat types, command, state and outcome codes, and the reply-type classifier.
// No dependencies.
`default_nettype none
package irhst_pkg;

  localparam int unsigned HostAw = 8;
  localparam logic [8:0] MaxHosts = 9'd256;
  localparam logic [10:0] MaxPacketBytes = 11'd1024;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_PKT  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_MARK = 2'd3;

  localparam logic [2:0] ST_NOREPLY  = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_UNREACH  = 3'd2;
  localparam logic [2:0] ST_TTL      = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_SENDFAIL = 3'd5;
  localparam logic [2:0] ST_OTHER    = 3'd6;

  localparam logic [1:0] OC_DONE   = 2'd0;
  localparam logic [1:0] OC_FULL   = 2'd1;
  localparam logic [1:0] OC_IGNORE = 2'd2;
  localparam logic [1:0] OC_EMPTY  = 2'd3;

  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TYPE_UNREACH    = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TYPE_TTL        = 8'd11;
  localparam logic [7:0] TYPE_SENDFAIL   = 8'd248;
  localparam logic [7:0] TYPE_BAD        = 8'd249;
  localparam logic [7:0] TYPE_NOREPLY    = 8'd250;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  entry_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] entry_address;
    logic [2:0]  host_state;
    logic [1:0]  outcome;
    logic [8:0]  pending_hosts;
    logic        all_answered;
  } out_beat_t;

  // Packet summary handed from the byte parser on the last byte.
  typedef struct packed {
    logic [7:0]  reply_type;
    logic        use_quoted;
    logic [31:0] quoted_target;
  } pkt_info_t;

  function automatic logic [2:0] classify(input logic [7:0] t);
    logic [2:0] s;
    case (t)
      TYPE_ECHO_REPLY: s = ST_OK;
      TYPE_UNREACH:    s = ST_UNREACH;
      TYPE_TTL:        s = ST_TTL;
      TYPE_SENDFAIL:   s = ST_SENDFAIL;
      TYPE_BAD:        s = ST_BAD;
      TYPE_NOREPLY:    s = ST_NOREPLY;
      default:         s = ST_OTHER;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/irhst_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module irhst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2**AddrW];
  logic [Width-1:0] rdata_q;

  // Write and read port; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/irhst_parser.sv */
// Packet byte parser: tracks position, header length, ICMP type and quoted target.
// Depends on irhst_pkg.
`default_nettype none
module irhst_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_en_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 last_byte_i,
  output irhst_pkg::pkt_info_t      info_o
);
  import irhst_pkg::*;

  logic [10:0] pos_q, pos_d;
  logic [5:0]  hb_q, hb_d;
  logic [7:0]  rt_q, rt_d;
  logic [31:0] qt_q, qt_d;
  logic        in_rng;
  logic [10:0] hb_w;
  logic [7:0]  ptype;

  // Fold the current byte into the running packet state.
  always_comb begin
    in_rng = pos_q < MaxPacketBytes;
    hb_d = hb_q;
    rt_d = rt_q;
    qt_d = qt_q;
    pos_d = pos_q;
    if (in_rng) begin
      if (pos_q == 11'd0) begin
        hb_d = {data_byte_i[3:0], 2'b00};
      end
      if (pos_q == {5'd0, hb_d}) begin
        rt_d = data_byte_i;
      end
      if (pos_q >= {5'd0, hb_d} + 11'd24 && pos_q < {5'd0, hb_d} + 11'd28) begin
        qt_d = {qt_q[23:0], data_byte_i};
      end
      pos_d = pos_q + 11'd1;
    end
    hb_w = {5'd0, hb_d};
  end

  // Classify the packet as it stands after this byte.
  always_comb begin
    ptype = (pos_d >= hb_w + 11'd8) ? rt_d : TYPE_BAD;
    info_o.use_quoted = 1'b0;
    if (ptype == TYPE_UNREACH || ptype == TYPE_TTL) begin
      if (pos_d >= hb_w + 11'd28) begin
        info_o.use_quoted = 1'b1;
      end else begin
        ptype = TYPE_BAD;
      end
    end
    info_o.reply_type = ptype;
    info_o.quoted_target = qt_d;
  end

  // Packet state registers, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hb_q <= '0;
      rt_q <= '0;
      qt_q <= '0;
    end else if (byte_en_i) begin
      if (last_byte_i) begin
        pos_q <= '0;
        hb_q <= '0;
        rt_q <= '0;
        qt_q <= '0;
      end else begin
        pos_q <= pos_d;
        hb_q <= hb_d;
        rt_q <= rt_d;
        qt_q <= qt_d;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/icmp_reply_host_status_table.sv */
// Top level of the ICMP reply host status table: command sequencer, table search, output beat.
// Depends on irhst_pkg, irhst_ram and irhst_parser.
//
// Usage: command beats enter on in_valid_i/in_stall_o, results leave on out_valid_o/out_stall_i.
// A beat is taken at a rising edge with valid high and stall low.
// A packet byte that is not the last is absorbed without leaving idle and gives no result.
// Add, mark and last-byte beats search the address memory one entry per cycle, pipelined
// behind its registered read, then pass through an update step before the result is staged.
// A read of a filled entry waits on the table read before its result is staged. A read of an
// empty index, an invalid add and an echo request go straight to result staging, with no search.
// One beat is worked on at a time; the next is taken as soon as the result has moved into
// the output register, even while that register waits on a stall.
// A stalled output holds its beat; the sequencer then waits before loading the next one.
// Reset clears the host count, pending count, packet state and the output valid. The table
// memories are not cleared; only data from entries below the host count is ever used.
`default_nettype none
module icmp_reply_host_status_table (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire irhst_pkg::in_beat_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output irhst_pkg::out_beat_t     out_data_o
);
  import irhst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [8:0]        cnt_q, cnt_d;
  logic [8:0]        pend_q, pend_d;
  logic [8:0]        scan_q, scan_d;
  logic              chk_q, chk_d;
  logic [HostAw-1:0] chk_idx_q, chk_idx_d;
  logic              hit_q, hit_d;
  logic [HostAw-1:0] hit_idx_q, hit_idx_d;
  logic [2:0]        old_st_q, old_st_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [31:0]       tgt_q, tgt_d;
  logic [2:0]        pst_q, pst_d;
  out_beat_t         res_q, res_d;
  out_beat_t         out_q;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic              take;
  logic              we;
  logic [HostAw-1:0] waddr;
  logic [2:0]        wst;
  logic [HostAw-1:0] raddr;
  logic [31:0]       addr_rdata;
  logic [2:0]        st_rdata;
  pkt_info_t         pinfo;
  logic [31:0]       ptarget;

  assign in_stall_o = state_q != S_IDLE;
  assign accept = in_valid_i && !in_stall_o;
  assign take = out_valid_q && !out_stall_i;

  irhst_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (accept && in_data_i.command == CMD_PKT),
    .data_byte_i (in_data_i.data_byte),
    .last_byte_i (in_data_i.last_byte),
    .info_o      (pinfo)
  );

  assign ptarget = pinfo.use_quoted ? pinfo.quoted_target : in_data_i.address;

  irhst_ram #(.Width(32), .AddrW(HostAw)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (tgt_q),
    .raddr_i (raddr),
    .rdata_o (addr_rdata)
  );

  irhst_ram #(.Width(3), .AddrW(HostAw)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wst),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  // Sequencer: decode, search, read-modify-write and result staging.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    pend_d = pend_q;
    scan_d = scan_q;
    chk_d = 1'b0;
    chk_idx_d = chk_idx_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    old_st_d = old_st_q;
    cmd_d = cmd_q;
    tgt_d = tgt_q;
    pst_d = pst_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !take;
    we = 1'b0;
    waddr = hit_idx_q;
    wst = ST_NOREPLY;
    raddr = scan_q[HostAw-1:0];

    unique case (state_q)
      S_IDLE: begin
        scan_d = '0;
        res_d = '{result_kind: in_data_i.command, entry_address: in_data_i.address,
                  host_state: ST_NOREPLY, outcome: OC_IGNORE, pending_hosts: pend_q,
                  all_answered: 1'b0};
        if (accept) begin
          cmd_d = in_data_i.command;
          tgt_d = in_data_i.address;
          unique case (in_data_i.command)
            CMD_ADD: begin
              if (in_data_i.address == '0 || in_data_i.address == '1) begin
                state_d = S_RESP;
              end else begin
                state_d = S_SRCH;
              end
            end
            CMD_READ: begin
              raddr = in_data_i.entry_index;
              if ({1'b0, in_data_i.entry_index} < cnt_q) begin
                state_d = S_RDW;
              end else begin
                res_d.entry_address = '0;
                res_d.outcome = OC_EMPTY;
                state_d = S_RESP;
              end
            end
            CMD_MARK: begin
              state_d = S_SRCH;
            end
            default: begin
              if (in_data_i.last_byte) begin
                tgt_d = ptarget;
                pst_d = classify(pinfo.reply_type);
                if (pinfo.reply_type == TYPE_ECHO_REQ) begin
                  res_d.entry_address = ptarget;
                  res_d.host_state = ST_OTHER;
                  state_d = S_RESP;
                end else begin
                  state_d = S_SRCH;
                end
              end
            end
          endcase
        end
      end

      S_SRCH: begin
        if (scan_q < cnt_q) begin
          chk_d = 1'b1;
          chk_idx_d = scan_q[HostAw-1:0];
          scan_d = scan_q + 9'd1;
        end
        if (chk_q && addr_rdata == tgt_q) begin
          hit_d = 1'b1;
          hit_idx_d = chk_idx_q;
          old_st_d = st_rdata;
          state_d = S_ACT;
        end else if (!chk_q && scan_q >= cnt_q) begin
          hit_d = 1'b0;
          state_d = S_ACT;
        end
      end

      S_RDW: begin
        res_d = '{result_kind: CMD_READ, entry_address: addr_rdata, host_state: st_rdata,
                  outcome: OC_DONE, pending_hosts: pend_q, all_answered: 1'b0};
        state_d = S_RESP;
      end

      S_ACT: begin
        res_d = '{result_kind: cmd_q, entry_address: tgt_q, host_state: ST_NOREPLY,
                  outcome: OC_IGNORE, pending_hosts: pend_q, all_answered: 1'b0};
        case (cmd_q)
          CMD_ADD: begin
            if (hit_q) begin
              we = 1'b1;
              if (old_st_q != ST_NOREPLY) begin
                pend_d = pend_q + 9'd1;
              end
              res_d.outcome = OC_DONE;
            end else if (cnt_q >= MaxHosts) begin
              res_d.outcome = OC_FULL;
            end else begin
              we = 1'b1;
              waddr = cnt_q[HostAw-1:0];
              cnt_d = cnt_q + 9'd1;
              pend_d = pend_q + 9'd1;
              res_d.outcome = OC_DONE;
            end
          end
          CMD_MARK: begin
            if (hit_q && old_st_q == ST_NOREPLY) begin
              we = 1'b1;
              wst = ST_SENDFAIL;
              pend_d = pend_q - 9'd1;
              res_d.host_state = ST_SENDFAIL;
              res_d.outcome = OC_DONE;
            end else if (hit_q) begin
              res_d.host_state = old_st_q;
            end
          end
          default: begin
            res_d.host_state = pst_q;
            if (hit_q && old_st_q != ST_OK) begin
              we = 1'b1;
              wst = pst_q;
              if (old_st_q == ST_NOREPLY && pst_q != ST_NOREPLY) begin
                pend_d = pend_q - 9'd1;
              end else if (old_st_q != ST_NOREPLY && pst_q == ST_NOREPLY) begin
                pend_d = pend_q + 9'd1;
              end
              res_d.outcome = OC_DONE;
              res_d.all_answered = pend_d == 9'd0;
            end
          end
        endcase
        res_d.pending_hosts = pend_d;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || take) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pend_q <= '0;
      scan_q <= '0;
      chk_q <= 1'b0;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
      scan_q <= scan_d;
      chk_q <= chk_d;
      hit_q <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; the output beat loads only when the slot is free.
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    old_st_q <= old_st_d;
    cmd_q <= cmd_d;
    tgt_q <= tgt_d;
    pst_q <= pst_d;
    res_q <= res_d;
    if (state_q == S_RESP && (!out_valid_q || take)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTH
  a_pend_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= cnt_q)
    else $error("pending count exceeds host count");
  a_write_only_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == S_ACT)
    else $error("table written outside the update step");
  a_all_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.all_answered |-> out_data_o.pending_hosts == 9'd0)
    else $error("all answered flagged with hosts pending");
`endif

endmodule
`default_nettype wire
